>>> design/conv2d_5x5_zero_pad_top_macros.svh
// ----------------------------------------------------------------------------
// conv2d_5x5_zero_pad_top macros
// Assertion macros for the 5x5 convolution block, clocked on clk and
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef CONV2D_5X5_ZERO_PAD_TOP_MACROS_SVH
`define CONV2D_5X5_ZERO_PAD_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// expr must hold at every clock edge
`define C2D_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// when ante holds, cons must hold in the next cycle
`define C2D_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define C2D_ASSERT(lbl, expr, msg)
`define C2D_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> design/c2d_pkg.sv
// ----------------------------------------------------------------------------
// c2d_pkg
// Shared types and constants of the 5x5 zero padded convolution block.
// ----------------------------------------------------------------------------
package c2d_pkg;

    localparam int KSIZE       = 5;
    localparam int KHALF       = 2;
    localparam int LINES       = KSIZE - 1;
    localparam int PIX_W       = 16;
    localparam int COEF_W      = 12;
    localparam int ROW_W       = KSIZE * COEF_W;
    localparam int SIZE_W      = 11;
    localparam int CNT_ROW_W   = SIZE_W + 1;
    localparam int LINE_WORD_W = LINES * PIX_W;
    localparam int PROD_W      = 28;
    localparam int PSUM_W      = 30;
    localparam int SUM_W       = 32;
    localparam int FIFO_DEPTH  = 8;
    localparam int FIFO_AW     = 3;
    localparam int FIFO_CNT_W  = 4;
    localparam int CFG_IDX_W   = 3;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_SIZE = 3'd0,
        REG_MASK_ROW_0 = 3'd1,
        REG_MASK_ROW_1 = 3'd2,
        REG_MASK_ROW_2 = 3'd3,
        REG_MASK_ROW_3 = 3'd4,
        REG_MASK_ROW_4 = 3'd5
    } cfg_reg_e;

    typedef enum logic {
        REQ_PIXEL = 1'b0,
        REQ_DRAIN = 1'b1
    } req_e;

    typedef logic signed [PIX_W-1:0] pixel_t;
    typedef pixel_t [KSIZE-1:0] column_t;
    typedef pixel_t [KSIZE-1:0][KSIZE-1:0] window_t;
    typedef logic [KSIZE-1:0][ROW_W-1:0] mask_t;

    typedef struct packed {
        logic               req_type;
        logic signed [PIX_W-1:0] pixel_value;
    } pix_item_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] conv_sum;
        logic                    last_of_frame;
    } res_item_t;

    // per-item control that travels beside the window data
    typedef struct packed {
        logic             emit;
        logic             last;
        logic [KSIZE-1:0] row_ok;
        logic [KSIZE-1:0] col_ok;
    } tap_ctl_t;

endpackage

>>> design/c2d_line_mem.sv
// ----------------------------------------------------------------------------
// c2d_line_mem
// Four line stores packed into one word per column. Each item reads its
// column, shifts the four rows by one and writes the word back in the next cycle.
// ----------------------------------------------------------------------------
module c2d_line_mem #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
    input  c2d_pkg::pixel_t              pix_in,
    output logic                         col_valid,
    output c2d_pkg::column_t             col
);
    import c2d_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);

    logic [LINE_WORD_W-1:0] line_ram [MAX_WIDTH];
    logic [LINE_WORD_W-1:0] rd_data_reg;
    logic                   s1_valid_reg;
    logic [AW-1:0]          s1_addr_reg;
    pixel_t                 s1_pix_reg;
    logic                   fwd_valid_reg;
    logic [AW-1:0]          fwd_addr_reg;
    logic [LINE_WORD_W-1:0] fwd_word_reg;
    logic [LINE_WORD_W-1:0] old_word;
    logic [LINE_WORD_W-1:0] new_word;

    // a write to the same column at the read edge is not yet in the ram data
    always_comb
    begin
        if (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg)) begin
            old_word = fwd_word_reg;
        end else begin
            old_word = rd_data_reg;
        end
        new_word = {old_word[LINE_WORD_W-PIX_W-1:0], s1_pix_reg};
        for (int i = 0; i < LINES; i++) begin
            col[i] = old_word[(LINES-i)*PIX_W-1 -: PIX_W];
        end
        col[LINES] = s1_pix_reg;
    end

    assign col_valid = s1_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= rd_en;
            fwd_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en) begin
            rd_data_reg <= line_ram[rd_addr];
            s1_addr_reg <= rd_addr;
            s1_pix_reg  <= pix_in;
        end
        if (s1_valid_reg) begin
            line_ram[s1_addr_reg] <= new_word;
        end
        fwd_addr_reg <= s1_addr_reg;
        fwd_word_reg <= new_word;
    end

endmodule

>>> design/c2d_window.sv
// ----------------------------------------------------------------------------
// c2d_window
// 5x5 window of pixels. A new column enters on the right for every item.
// ----------------------------------------------------------------------------
module c2d_window (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               shift,
    input  c2d_pkg::column_t   col,
    input  c2d_pkg::tap_ctl_t  ctl_in,
    output c2d_pkg::window_t   win,
    output c2d_pkg::tap_ctl_t  ctl_out
);
    import c2d_pkg::*;

    window_t  window_reg;
    window_t  window_next;
    tap_ctl_t ctl_reg;

    always_comb
    begin
        for (int i = 0; i < KSIZE; i++) begin
            for (int j = 0; j < KSIZE - 1; j++) begin
                window_next[i][j] = window_reg[i][j+1];
            end
            window_next[i][KSIZE-1] = col[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift) begin
            window_reg <= window_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ctl_reg <= '0;
        end else begin
            ctl_reg <= ctl_in;
        end
    end

    assign win     = window_reg;
    assign ctl_out = ctl_reg;

endmodule

>>> design/c2d_mac.sv
// ----------------------------------------------------------------------------
// c2d_mac
// 25 masked products, then row sums, then the final sum, one register level
// after each of the first two steps; the final sum is combinational.
// ----------------------------------------------------------------------------
module c2d_mac (
    input  logic               clk,
    input  logic               rst_n,
    input  c2d_pkg::window_t   win,
    input  c2d_pkg::mask_t     mask,
    input  c2d_pkg::tap_ctl_t  ctl_in,
    output c2d_pkg::res_item_t item,
    output logic               push,
    output logic [1:0]         inflight
);
    import c2d_pkg::*;

    logic signed [COEF_W-1:0] coef     [KSIZE][KSIZE];
    logic signed [PIX_W-1:0]  px       [KSIZE][KSIZE];
    logic signed [PROD_W-1:0] prod_next[KSIZE][KSIZE];
    logic signed [PROD_W-1:0] prod_reg [KSIZE][KSIZE];
    logic signed [PSUM_W-1:0] psum_next[KSIZE];
    logic signed [PSUM_W-1:0] psum_reg [KSIZE];
    logic signed [SUM_W-1:0]  sum_total;
    tap_ctl_t                 ctl3_reg;
    tap_ctl_t                 ctl4_reg;

    // taps outside the image read as zero
    always_comb
    begin
        for (int i = 0; i < KSIZE; i++) begin
            for (int j = 0; j < KSIZE; j++) begin
                coef[i][j] = $signed(mask[i][j*COEF_W +: COEF_W]);
                if (ctl_in.row_ok[i] && ctl_in.col_ok[j]) begin
                    px[i][j] = $signed(win[i][j]);
                end else begin
                    px[i][j] = '0;
                end
                prod_next[i][j] = PROD_W'(coef[i][j]) * PROD_W'(px[i][j]);
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < KSIZE; i++) begin
            psum_next[i] = '0;
            for (int j = 0; j < KSIZE; j++) begin
                psum_next[i] = psum_next[i] + PSUM_W'(prod_reg[i][j]);
            end
        end
        sum_total = '0;
        for (int i = 0; i < KSIZE; i++) begin
            sum_total = sum_total + SUM_W'(psum_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        psum_reg <= psum_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ctl3_reg <= '0;
            ctl4_reg <= '0;
        end else begin
            ctl3_reg <= ctl_in;
            ctl4_reg <= ctl3_reg;
        end
    end

    assign item.conv_sum      = sum_total;
    assign item.last_of_frame = ctl4_reg.last;
    assign push               = ctl4_reg.emit;
    assign inflight           = {1'b0, ctl3_reg.emit} + {1'b0, ctl4_reg.emit};

endmodule

>>> design/c2d_fifo.sv
// ----------------------------------------------------------------------------
// c2d_fifo
// Small result queue that decouples the arithmetic pipeline from the
// downstream stall.
// ----------------------------------------------------------------------------
module c2d_fifo (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    input  c2d_pkg::res_item_t                 push_item,
    output logic                               valid,
    input  logic                               stall,
    output c2d_pkg::res_item_t                 item,
    output logic [c2d_pkg::FIFO_CNT_W-1:0]     count
);
    import c2d_pkg::*;

    res_item_t             entry_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]    wr_ptr_reg;
    logic [FIFO_AW-1:0]    rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] cnt_reg;
    logic [FIFO_CNT_W-1:0] cnt_next;
    logic                  pop;

    assign valid = (cnt_reg != '0);
    assign pop   = valid && !stall;
    assign item  = entry_reg[rd_ptr_reg];
    assign count = cnt_reg;

    always_comb
    begin
        cnt_next = cnt_reg + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

endmodule

>>> design/conv2d_5x5_zero_pad_top.sv
// ----------------------------------------------------------------------------
// conv2d_5x5_zero_pad_top
// 5x5 zero padded correlation over a square raster image. The block takes one
// item per clock unless stalled: a pixel read-modify-writes its column in the
// packed line store (read at the accept edge, written back next cycle and
// forwarded when the same column comes right back, as with a one pixel image),
// so the line store port sets the rate of one item per cycle. A result goes
// past the window and MAC registers to the queue after the item completing its
// window, 2*size+2 items later; the source sends that many drain items after
// the frame, and the last result carries last_of_frame. Results wait in an
// eight entry queue; pix_stall rises only when queued plus in-flight results
// would fill it. The line store needs no clearing after reset: taps above,
// below or beside the image are forced to zero. Writing image_size restarts
// the frame; sizes of 0 act as 1 and sizes above MAX_WIDTH act as MAX_WIDTH.
// ----------------------------------------------------------------------------
`include "conv2d_5x5_zero_pad_top_macros.svh"

module conv2d_5x5_zero_pad_top #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             pix_valid,
    output logic                             pix_stall,
    input  c2d_pkg::pix_item_t               pix,
    output logic                             res_valid,
    input  logic                             res_stall,
    output c2d_pkg::res_item_t               res,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [c2d_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [c2d_pkg::ROW_W-1:0]        cfg_data
);
    import c2d_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);

    logic [SIZE_W-1:0]    size_reg;
    logic [SIZE_W-1:0]    size_next;
    mask_t                mask_reg;
    mask_t                mask_next;
    logic [SIZE_W-1:0]    ic_reg;
    logic [SIZE_W-1:0]    ic_next;
    logic [CNT_ROW_W-1:0] ir_reg;
    logic [CNT_ROW_W-1:0] ir_next;
    logic [SIZE_W-1:0]    orow_reg;
    logic [SIZE_W-1:0]    orow_next;
    logic [SIZE_W-1:0]    ocol_reg;
    logic [SIZE_W-1:0]    ocol_next;
    tap_ctl_t             s1_ctl_reg;
    tap_ctl_t             tap_now;

    logic [SIZE_W-1:0]     n_eff;
    logic [CNT_ROW_W-1:0]  n_ext;
    logic [CNT_ROW_W-1:0]  ic_ext;
    logic [CNT_ROW_W-1:0]  orow_ext;
    logic [CNT_ROW_W-1:0]  ocol_ext;
    logic                  accept;
    logic                  cfg_write;
    logic                  size_write;
    logic                  in_frame;
    logic                  emit_now;
    logic                  last_now;
    pixel_t                pix_in;

    column_t               col;
    logic                  col_valid;
    window_t               win;
    tap_ctl_t              s2_ctl;
    res_item_t             mac_item;
    logic                  mac_push;
    logic [1:0]            mac_inflight;
    logic [FIFO_CNT_W-1:0] fifo_count;
    logic [FIFO_CNT_W-1:0] pending;

    assign cfg_ready  = 1'b1;
    assign cfg_write  = cfg_valid && cfg_ready;
    assign size_write = cfg_write && (cfg_index == REG_IMAGE_SIZE);
    assign accept     = pix_valid && !pix_stall;

    always_comb
    begin
        if (size_reg == '0) begin
            n_eff = SIZE_W'(1);
        end else if (int'(size_reg) > MAX_WIDTH) begin
            n_eff = SIZE_W'(MAX_WIDTH);
        end else begin
            n_eff = size_reg;
        end
    end

    assign n_ext    = {1'b0, n_eff};
    assign ic_ext   = {1'b0, ic_reg};
    assign orow_ext = {1'b0, orow_reg};
    assign ocol_ext = {1'b0, ocol_reg};

    // positions past the last pixel, and drain items, enter as zero
    assign in_frame = (ir_reg < n_ext);
    assign pix_in   = (pix.req_type == REQ_PIXEL && in_frame) ? pix.pixel_value : '0;

    // results start once the stream is two rows plus two pixels ahead
    always_comb
    begin
        if (n_eff == SIZE_W'(1)) begin
            emit_now = (ir_reg >= CNT_ROW_W'(2 * KHALF));
        end else begin
            emit_now = (ir_reg >= CNT_ROW_W'(KHALF + 1))
                    || ((ir_reg == CNT_ROW_W'(KHALF)) && (ic_ext >= CNT_ROW_W'(KHALF)));
        end
        last_now = emit_now
                && (orow_ext == n_ext - 1'b1)
                && (ocol_ext == n_ext - 1'b1);
    end

    // border taps of the output position
    always_comb
    begin
        tap_now.emit = accept && emit_now;
        tap_now.last = last_now;
        for (int i = 0; i < KSIZE; i++) begin
            if (i < KHALF) begin
                tap_now.row_ok[i] = (orow_ext >= CNT_ROW_W'(KHALF - i));
                tap_now.col_ok[i] = (ocol_ext >= CNT_ROW_W'(KHALF - i));
            end else begin
                tap_now.row_ok[i] = ((orow_ext + CNT_ROW_W'(i - KHALF)) < n_ext);
                tap_now.col_ok[i] = ((ocol_ext + CNT_ROW_W'(i - KHALF)) < n_ext);
            end
        end
    end

    // stream and output position
    always_comb
    begin
        ic_next   = ic_reg;
        ir_next   = ir_reg;
        orow_next = orow_reg;
        ocol_next = ocol_reg;
        priority if (size_write) begin
            ic_next   = '0;
            ir_next   = '0;
            orow_next = '0;
            ocol_next = '0;
        end else if (accept) begin
            if (last_now) begin
                ic_next   = '0;
                ir_next   = '0;
                orow_next = '0;
                ocol_next = '0;
            end else begin
                if ((ic_ext + 1'b1) >= n_ext) begin
                    ic_next = '0;
                    ir_next = ir_reg + 1'b1;
                end else begin
                    ic_next = ic_reg + 1'b1;
                end
                if (emit_now) begin
                    if ((ocol_ext + 1'b1) >= n_ext) begin
                        ocol_next = '0;
                        orow_next = orow_reg + 1'b1;
                    end else begin
                        ocol_next = ocol_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_comb
    begin
        size_next = size_reg;
        mask_next = mask_reg;
        if (cfg_write) begin
            unique case (cfg_index)
                REG_IMAGE_SIZE: size_next    = cfg_data[SIZE_W-1:0];
                REG_MASK_ROW_0: mask_next[0] = cfg_data;
                REG_MASK_ROW_1: mask_next[1] = cfg_data;
                REG_MASK_ROW_2: mask_next[2] = cfg_data;
                REG_MASK_ROW_3: mask_next[3] = cfg_data;
                REG_MASK_ROW_4: mask_next[4] = cfg_data;
                default:        size_next    = size_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            size_reg   <= SIZE_RESET;
            mask_reg   <= '0;
            ic_reg     <= '0;
            ir_reg     <= '0;
            orow_reg   <= '0;
            ocol_reg   <= '0;
            s1_ctl_reg <= '0;
        end else begin
            size_reg   <= size_next;
            mask_reg   <= mask_next;
            ic_reg     <= ic_next;
            ir_reg     <= ir_next;
            orow_reg   <= orow_next;
            ocol_reg   <= ocol_next;
            s1_ctl_reg <= accept ? tap_now : '0;
        end
    end

    // every result already accepted must find room in the queue
    assign pending = fifo_count
                   + FIFO_CNT_W'(s1_ctl_reg.emit)
                   + FIFO_CNT_W'(s2_ctl.emit)
                   + FIFO_CNT_W'(mac_inflight);
    assign pix_stall = (pending >= FIFO_CNT_W'(FIFO_DEPTH));

    c2d_line_mem #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_mem (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (accept),
        .rd_addr   (AW'(ic_reg)),
        .pix_in    (pix_in),
        .col_valid (col_valid),
        .col       (col)
    );

    c2d_window u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .shift   (col_valid),
        .col     (col),
        .ctl_in  (s1_ctl_reg),
        .win     (win),
        .ctl_out (s2_ctl)
    );

    c2d_mac u_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .win      (win),
        .mask     (mask_reg),
        .ctl_in   (s2_ctl),
        .item     (mac_item),
        .push     (mac_push),
        .inflight (mac_inflight)
    );

    c2d_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (mac_push),
        .push_item (mac_item),
        .valid     (res_valid),
        .stall     (res_stall),
        .item      (res),
        .count     (fifo_count)
    );

    `C2D_ASSERT(a_queue_credit, pending <= FIFO_CNT_W'(FIFO_DEPTH), "result queue overcommitted")
    `C2D_ASSERT(a_out_pos_range, (orow_reg < n_eff) && (ocol_reg < n_eff) && (ic_reg < n_eff), "position outside image")
    `C2D_ASSERT_NEXT(a_frame_restart, accept && last_now, (ic_reg == '0) && (ir_reg == '0) && (orow_reg == '0) && (ocol_reg == '0), "frame did not restart")

endmodule

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 5x5 zero padded convolution block. Square
// frames of random size are streamed in raster order with their drain items,
// while both channels idle and stall at random. Every accepted item is fed to
// an in-bench window sum predictor, and each result item is compared field by
// field with the oldest predicted sum. Image size and mask rows are rewritten
// between phases, the extremes among them.
// ----------------------------------------------------------------------------
module testbench;
    import c2d_pkg::*;

    localparam int     MAX_W        = 1024;
    localparam int     HIST_DEPTH   = 4 * MAX_W + 8;
    localparam int     SETTLE       = 16;
    localparam int     HOLD_CYCLES  = 200;
    localparam int     RANDOM_ITEMS = 300;
    localparam int     WIDE_ITEMS   = 64;
    localparam int     MAX_REPORTS  = 10;
    localparam longint CYCLE_LIMIT  = 2000000;

    // indexes past the register list, writes there are ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam pixel_t PIX_MIN = 16'sh8000;
    localparam pixel_t PIX_MAX = 16'sh7FFF;

    typedef enum int {
        FILL_RANDOM,
        FILL_MIN,
        FILL_MAX,
        FILL_SPARSE,
        FILL_ZERO
    } fill_e;

    class window_sum_board;
        logic [SIZE_W-1:0] size_reg;
        logic [ROW_W-1:0]  mask_rows [KSIZE];
        pixel_t            history [HIST_DEPTH];
        int                in_row;
        int                in_col;
        int                out_pos;
        res_item_t         sums_due [$];
        int                errors;

        function new();
            size_reg = SIZE_RESET;
            foreach (mask_rows[i])
                mask_rows[i] = '0;
            foreach (history[i])
                history[i] = '0;
            errors = 0;
            restart();
        endfunction

        function void restart();
            in_row  = 0;
            in_col  = 0;
            out_pos = 0;
        endfunction

        function int side();
            if (size_reg == 0)
                return 1;
            if (size_reg > MAX_W)
                return MAX_W;
            return int'(size_reg);
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [ROW_W-1:0] data);
            if (idx == REG_IMAGE_SIZE)
            begin
                size_reg = data[SIZE_W-1:0];
                restart();
            end
            else if (idx >= REG_MASK_ROW_0 && idx <= REG_MASK_ROW_4)
            begin
                mask_rows[idx - REG_MASK_ROW_0] = data;
            end
        endfunction

        function void take_pixel(pix_item_t it);
            int                       n;
            int                       total;
            int                       k;
            int                       r;
            int                       c;
            int                       rr;
            int                       cc;
            longint                   acc;
            pixel_t                   v;
            logic signed [COEF_W-1:0] cf;
            res_item_t                sum_item;
            n     = side();
            total = n * n;
            k     = in_row * n + in_col;
            v     = '0;
            // drain items in the frame and pixels past it both count as zero
            if (it.req_type == REQ_PIXEL && k < total)
                v = it.pixel_value;
            history[k % HIST_DEPTH] = v;
            in_col++;
            if (in_col >= n)
            begin
                in_col = 0;
                in_row++;
            end
            if (k < 2 * n + 2)
                return;
            r   = out_pos / n;
            c   = out_pos % n;
            acc = 0;
            for (int i = 0; i < KSIZE; i++)
            begin
                for (int j = 0; j < KSIZE; j++)
                begin
                    rr = r + i - KHALF;
                    cc = c + j - KHALF;
                    if (rr >= 0 && rr < n && cc >= 0 && cc < n)
                    begin
                        cf  = mask_rows[i][COEF_W*j +: COEF_W];
                        acc += longint'(cf) * longint'(history[(rr * n + cc) % HIST_DEPTH]);
                    end
                end
            end
            sum_item.conv_sum      = acc[SUM_W-1:0];
            sum_item.last_of_frame = (out_pos + 1 >= total);
            sums_due.push_back(sum_item);
            out_pos++;
            if (sum_item.last_of_frame)
                restart();
        endfunction

        function void check_sum(res_item_t got);
            res_item_t want;
            if (sums_due.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected result: sum %0d last %0b",
                             got.conv_sum, got.last_of_frame);
                return;
            end
            want = sums_due.pop_front();
            if (got.conv_sum !== want.conv_sum || got.last_of_frame !== want.last_of_frame)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("mismatch: expected sum %0d last %0b, got sum %0d last %0b",
                             want.conv_sum, want.last_of_frame,
                             got.conv_sum, got.last_of_frame);
            end
        endfunction

        function int pending();
            return sums_due.size();
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 pix_valid = 1'b0;
    logic                 pix_stall;
    pix_item_t            pix       = '0;
    logic                 res_valid;
    logic                 res_stall = 1'b0;
    res_item_t            res;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [ROW_W-1:0]     cfg_data  = '0;

    window_sum_board sb;
    longint          cycle_count = 0;
    int              items_sent  = 0;
    bit              burst       = 1'b0;
    bit              hold_req    = 1'b0;

    conv2d_5x5_zero_pad_top #(
        .MAX_WIDTH (MAX_W)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix       (pix),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
            sb.check_sum(res);
    end

    // receiver stalls: random runs, plus one long hold-off on request
    initial
    begin
        int run_left;
        int hold_left;
        int r;
        bit run_val;
        run_left  = 0;
        hold_left = 0;
        run_val   = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left == 0 && hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_stall <= 1'b1;
            end
            else
            begin
                if (run_left == 0)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 50)
                    begin
                        run_val  = 1'b0;
                        run_left = $urandom_range(1, 40);
                    end
                    else if (r < 92)
                    begin
                        run_val  = 1'b1;
                        run_left = $urandom_range(1, 3);
                    end
                    else
                    begin
                        run_val  = 1'b1;
                        run_left = $urandom_range(10, 60);
                    end
                end
                run_left--;
                res_stall <= run_val;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic pixel_t rand_pixel();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return PIX_MIN;
        if (r < 20)
            return PIX_MAX;
        if (r < 25)
            return '0;
        return pixel_t'($urandom);
    endfunction

    function automatic pix_item_t mk_item(req_e kind, pixel_t value);
        pix_item_t it;
        it.req_type    = kind;
        it.pixel_value = value;
        return it;
    endfunction

    function automatic logic [ROW_W-1:0] mask_word(fill_e mode);
        logic [ROW_W-1:0]  w;
        logic [COEF_W-1:0] cf;
        w = '0;
        for (int j = 0; j < KSIZE; j++)
        begin
            case (mode)
                FILL_RANDOM: cf = COEF_W'($urandom);
                FILL_MIN:    cf = 12'h800;
                FILL_MAX:    cf = 12'h7FF;
                FILL_SPARSE: cf = ($urandom_range(0, 2) == 0) ?
                                  COEF_W'($urandom_range(0, 31)) - 12'd16 : '0;
                default:     cf = '0;
            endcase
            w[COEF_W*j +: COEF_W] = cf;
        end
        return w;
    endfunction

    // size in the low bits, junk above them
    function automatic logic [ROW_W-1:0] size_word(int s);
        logic [ROW_W-1:0] w;
        w = ROW_W'({$urandom, $urandom});
        w[SIZE_W-1:0] = SIZE_W'(s);
        return w;
    endfunction

    task automatic send_pix(pix_item_t it);
        int gap;
        gap = burst ? 0 : pick_gap();
        if (gap > 0)
        begin
            pix_valid <= 1'b0;
            pix       <= pix_item_t'($urandom);
            repeat (gap) @(posedge clk);
        end
        pix_valid <= 1'b1;
        pix       <= it;
        @(posedge clk);
        while (pix_stall)
            @(posedge clk);
        sb.take_pixel(it);
        items_sent++;
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // source quiet, all sums in, pipeline settled
    task automatic wait_idle();
        pix_valid <= 1'b0;
        wait_drained();
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [ROW_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    task automatic cfg_masks(fill_e mode);
        cfg_write(REG_MASK_ROW_0, mask_word(mode));
        cfg_write(REG_MASK_ROW_1, mask_word(mode));
        cfg_write(REG_MASK_ROW_2, mask_word(mode));
        cfg_write(REG_MASK_ROW_3, mask_word(mode));
        cfg_write(REG_MASK_ROW_4, mask_word(mode));
    endtask

    task automatic send_frame(int n, bit flat, bit cut);
        int        total;
        int        span;
        int        stop_at;
        pixel_t    flat_val;
        pix_item_t it;
        total    = n * n;
        span     = total + 2 * n + 2;
        stop_at  = cut ? $urandom_range(1, span - 1) : span;
        flat_val = ($urandom_range(0, 1) == 0) ? PIX_MIN : PIX_MAX;
        for (int k = 0; k < stop_at; k++)
        begin
            if (k == total && $urandom_range(0, 9) == 0)
            begin
                pix_valid <= 1'b0;
                wait_drained();
                @(posedge clk);
            end
            if (k < total)
            begin
                it.req_type    = ($urandom_range(0, 24) == 0) ? REQ_DRAIN : REQ_PIXEL;
                it.pixel_value = flat ? flat_val : rand_pixel();
            end
            else
            begin
                it.req_type    = ($urandom_range(0, 19) == 0) ? REQ_PIXEL : REQ_DRAIN;
                it.pixel_value = rand_pixel();
            end
            send_pix(it);
        end
    endtask

    task automatic run_directed();
        // size 0 acts as 1, every coefficient at its negative extreme
        cfg_write(REG_IMAGE_SIZE, size_word(0));
        cfg_masks(FILL_MIN);
        cfg_write(CFG_SPARE_LO, ROW_W'({$urandom, $urandom}));
        cfg_valid <= 1'b0;
        send_pix(mk_item(REQ_PIXEL, PIX_MIN));
        repeat (4) send_pix(mk_item(REQ_DRAIN, rand_pixel()));
        // drain inside the frame, then pixels after it
        send_pix(mk_item(REQ_DRAIN, PIX_MAX));
        repeat (4) send_pix(mk_item(REQ_PIXEL, PIX_MAX));
        wait_idle();

        cfg_write(REG_IMAGE_SIZE, size_word(1));
        cfg_masks(FILL_MAX);
        cfg_write(CFG_SPARE_HI, ROW_W'({$urandom, $urandom}));
        cfg_valid <= 1'b0;
        send_pix(mk_item(REQ_PIXEL, PIX_MAX));
        repeat (4) send_pix(mk_item(REQ_DRAIN, PIX_MIN));
        wait_idle();

        cfg_write(REG_IMAGE_SIZE, size_word(2));
        cfg_write(REG_MASK_ROW_0, mask_word(FILL_RANDOM));
        cfg_write(REG_MASK_ROW_1, mask_word(FILL_MIN));
        cfg_write(REG_MASK_ROW_2, mask_word(FILL_MAX));
        cfg_write(REG_MASK_ROW_3, mask_word(FILL_MIN));
        cfg_write(REG_MASK_ROW_4, mask_word(FILL_MAX));
        cfg_valid <= 1'b0;
        send_pix(mk_item(REQ_PIXEL, PIX_MIN));
        send_pix(mk_item(REQ_PIXEL, PIX_MAX));
        send_pix(mk_item(REQ_PIXEL, PIX_MAX));
        send_pix(mk_item(REQ_PIXEL, PIX_MIN));
        repeat (6) send_pix(mk_item(REQ_DRAIN, rand_pixel()));
        wait_idle();
    endtask

    // receiver holds off while full windows at the extremes keep coming
    task automatic run_pressure();
        cfg_write(REG_IMAGE_SIZE, size_word(5));
        cfg_masks(FILL_MIN);
        cfg_valid <= 1'b0;
        @(posedge clk);
        hold_req = 1'b1;
        burst    = 1'b1;
        repeat (3) send_frame(5, 1'b1, 1'b0);
        burst = 1'b0;
        wait_idle();
    endtask

    task automatic run_random();
        int    base;
        int    n;
        int    r;
        int    frames;
        bit    first;
        bit    same_fill;
        fill_e fill;
        base  = items_sent;
        first = 1'b1;
        n     = 5;
        while (items_sent - base < RANDOM_ITEMS)
        begin
            if (first || $urandom_range(0, 4) != 0)
            begin
                r = $urandom_range(0, 99);
                if (r < 5)
                    n = 0;
                else if (r < 40)
                    n = $urandom_range(1, 4);
                else if (r < 80)
                    n = $urandom_range(5, 8);
                else if (r < 95)
                    n = $urandom_range(9, 16);
                else
                    n = $urandom_range(17, 24);
                cfg_write(REG_IMAGE_SIZE, size_word(n));
                if (n == 0)
                    n = 1;
            end
            same_fill = ($urandom_range(0, 3) == 0);
            fill      = fill_e'($urandom_range(0, 4));
            for (int i = 0; i < KSIZE; i++)
            begin
                if (first || $urandom_range(0, 9) < 6)
                begin
                    if (!same_fill)
                        fill = fill_e'($urandom_range(0, 4));
                    cfg_write(CFG_IDX_W'(REG_MASK_ROW_0 + i), mask_word(fill));
                end
            end
            if ($urandom_range(0, 9) == 0)
                cfg_write($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI,
                          ROW_W'({$urandom, $urandom}));
            cfg_valid <= 1'b0;
            first  = 1'b0;
            burst  = ($urandom_range(0, 3) == 0);
            frames = $urandom_range(1, 3);
            for (int f = 0; f < frames; f++)
                send_frame(n, $urandom_range(0, 9) == 0,
                           f == frames - 1 && $urandom_range(0, 11) == 0);
            burst = 1'b0;
            wait_idle();
        end
    endtask

    // widest size clamps to the maximum width; a short stretch, no sum yet due
    task automatic run_widest();
        cfg_write(REG_IMAGE_SIZE, size_word(2047));
        cfg_masks(FILL_RANDOM);
        cfg_valid <= 1'b0;
        burst = 1'b1;
        for (int k = 0; k < WIDE_ITEMS; k++)
            send_pix(mk_item(REQ_PIXEL, rand_pixel()));
        burst = 1'b0;
        wait_idle();
    endtask

    initial
    begin
        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_pressure();
        run_random();
        run_widest();
        pix_valid <= 1'b0;
        wait_drained();
        repeat (4 * SETTLE) @(posedge clk);
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
